// ===== hdl/snell_refraction_direction_defines.svh =====
// Assertion macros for the refraction block.
// Used by snell_refraction_direction.sv; needs clk and rst_n in scope.
`ifndef SNELL_REFRACTION_DIRECTION_DEFINES_SVH
`define SNELL_REFRACTION_DIRECTION_DEFINES_SVH

// same-cycle implication, off while in reset
`define SRD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define SRD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/srd_pkg.sv =====
// Shared constants, types and rounding helpers for the refraction pipeline.
// No dependencies; used by snell_refraction_direction.
package srd_pkg;

  localparam int F      = 14;   // fraction bits of normal and result
  localparam int RF     = 12;   // fraction bits of index ratio
  localparam int ONE_F  = 1 << F;

  localparam int VW     = 24;   // incident component
  localparam int NW     = 16;   // normal component
  localparam int RAT_W  = 15;   // index ratio
  localparam int OW     = 16;   // result component

  localparam int IN_DATA_W  = 136;
  localparam int OUT_DATA_W = 48;
  localparam int OFS_N      = 3 * VW;
  localparam int OFS_R      = 3 * VW + 3 * NW;

  localparam int MAG_W   = VW;      // |v| fits unsigned
  localparam int SQ_W    = 47;      // v*v
  localparam int LEN_W   = 48;      // sum of squares
  localparam int PAIRS   = LEN_W / 2;
  localparam int GROUPS  = PAIRS / 4;
  localparam int NORM_W  = 62;      // normalized length, top pair at bits 61:60
  localparam int TOP_PAIR = NORM_W / 2 - 1;
  localparam int S_W     = 5;
  localparam int HP_W    = 5;
  localparam int L_W     = NORM_W / 2;
  localparam int MAGS_W  = L_W;     // |v| << s never exceeds L
  localparam int NUM_W   = MAGS_W + F + 1;
  localparam int Q_W     = F + 1;
  localparam int Q_MAX   = 1 << F;
  localparam int U_W     = 16;
  localparam int PR_W    = 32;
  localparam int ACC_W   = 34;
  localparam int DT_W    = 18;
  localparam int DSQ_W   = 36;
  localparam int R2_W    = 2 * RAT_W;
  localparam int ND_W    = 34;
  localparam int M_W     = 22;
  localparam int W_W     = 20;
  localparam int RM_W    = 52;
  localparam int RWP_W   = 36;
  localparam int DISC_W  = 28;
  localparam int DISC_MAG_W = 26;
  localparam int DSQ_IN_W   = DISC_MAG_W + F;
  localparam int SQ2_W      = DSQ_IN_W / 2;
  localparam int P_W     = 24;
  localparam int QN_W    = 37;
  localparam int O_PRE_W = 26;

  typedef struct packed {
    logic [2:0][VW-1:0]    v;
    logic [2:0][NW-1:0]    n;
    logic [RAT_W-1:0]      r;
  } ray_t;

  typedef struct packed {
    logic                  zero;
    logic [2:0]            neg;
    logic [2:0][MAGS_W-1:0] mag;
    logic [2:0][NW-1:0]    n;
    logic [RAT_W-1:0]      r;
  } len_side_t;

  typedef struct packed {
    logic                  zero;
    logic [2:0]            neg;
    logic [2:0][NW-1:0]    n;
    logic [RAT_W-1:0]      r;
  } div_side_t;

  typedef struct packed {
    logic                  ok;
    logic [2:0][P_W-1:0]   p;
    logic [2:0][NW-1:0]    n;
  } disc_side_t;

  // divide by 2^k, round half away from zero
  function automatic logic signed [63:0] rnd(input logic signed [63:0] x, input int k);
    logic signed [63:0] half;
    logic signed [63:0] adj;
    half = 64'sd1 <<< (k - 1);
    adj  = x[63] ? half - 64'sd1 : half;
    return (x + adj) >>> k;
  endfunction

  function automatic logic [OW-1:0] sat_out(input logic signed [O_PRE_W-1:0] x);
    logic signed [O_PRE_W-1:0] hi;
    logic signed [O_PRE_W-1:0] lo;
    hi = O_PRE_W'(32767);
    lo = O_PRE_W'(-32768);
    if (x > hi) return OW'(hi);
    if (x < lo) return OW'(lo);
    return OW'(x);
  endfunction

endpackage

// ===== hdl/srd_isqrt.sv =====
// Pipelined integer square root, one result bit per stage, sideband carried along.
// No package dependencies; instantiated by snell_refraction_direction.
module srd_isqrt #(
  parameter int IN_W   = 62,
  parameter int SIDE_W = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_vld,
  input  logic [IN_W-1:0]   in_x,
  input  logic [SIDE_W-1:0] in_side,
  output logic              out_vld,
  output logic [IN_W/2-1:0] out_root,
  output logic [SIDE_W-1:0] out_side
);
  localparam int RT_W = IN_W / 2;
  localparam int AW   = IN_W + 2;

  logic [RT_W-1:0]   vld_r;
  logic [IN_W-1:0]   rem_r    [RT_W];
  logic [IN_W-1:0]   rem_nxt  [RT_W];
  logic [IN_W-1:0]   rem_in   [RT_W];
  logic [RT_W-1:0]   root_r   [RT_W];
  logic [RT_W-1:0]   root_nxt [RT_W];
  logic [RT_W-1:0]   root_in  [RT_W];
  logic [SIDE_W-1:0] side_r   [RT_W];

  always_comb begin
    rem_in[0]  = in_x;
    root_in[0] = '0;
    for (int j = 1; j < RT_W; j++) begin
      rem_in[j]  = rem_r[j-1];
      root_in[j] = root_r[j-1];
    end
  end

  // rem holds x - root^2; try setting the next root bit
  always_comb begin
    logic [AW-1:0] trial;
    for (int j = 0; j < RT_W; j++) begin
      trial = (AW'(root_in[j]) << (RT_W - j)) + (AW'(1) << (2 * (RT_W - 1 - j)));
      if (AW'(rem_in[j]) >= trial) begin
        rem_nxt[j]  = IN_W'(AW'(rem_in[j]) - trial);
        root_nxt[j] = root_in[j] | (RT_W'(1) << (RT_W - 1 - j));
      end else begin
        rem_nxt[j]  = rem_in[j];
        root_nxt[j] = root_in[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= (vld_r << 1) | RT_W'(in_vld);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < RT_W; j++) begin
        rem_r[j]  <= rem_nxt[j];
        root_r[j] <= root_nxt[j];
      end
      side_r[0] <= in_side;
      for (int j = 1; j < RT_W; j++) begin
        side_r[j] <= side_r[j-1];
      end
    end
  end

  assign out_vld  = vld_r[RT_W-1];
  assign out_root = root_r[RT_W-1];
  assign out_side = side_r[RT_W-1];

endmodule

// ===== hdl/snell_refraction_direction.sv =====
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while a finished word waits at the output register.
// Depth is set by the two bit-serial square roots (31 and 20 stages) and the
// 15-stage restoring divider. Reset (rst_n low, synchronous) empties all stages.
`include "snell_refraction_direction_defines.svh"

module snell_refraction_direction (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // incident_x, incident_y, incident_z, normal_x, normal_y, normal_z, index_ratio, pad
  input  logic [srd_pkg::IN_DATA_W-1:0]     in_tdata,
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // refracted_x, refracted_y, refracted_z
  output logic [srd_pkg::OUT_DATA_W-1:0]    out_tdata,
  // refracts
  output logic [0:0]                        out_tuser
);
  import srd_pkg::*;

  localparam int DIV_STEPS = Q_W;

  logic en;
  assign en        = ~out_tvalid | out_tready;
  assign in_tready = en;

  // ---------------- stage 1: squares
  logic signed [VW-1:0] inc [3];
  logic signed [LEN_W-1:0] vsq [3];
  ray_t in_ray;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      inc[i]      = $signed(in_tdata[i*VW +: VW]);
      vsq[i]      = LEN_W'(inc[i]) * LEN_W'(inc[i]);
      in_ray.v[i] = in_tdata[i*VW +: VW];
      in_ray.n[i] = in_tdata[OFS_N + i*NW +: NW];
    end
    in_ray.r = in_tdata[OFS_R +: RAT_W];
  end

  logic s1_vld_r, s2_vld_r, s3_vld_r, s4_vld_r, s5_vld_r;
  logic [SQ_W-1:0] s1_sq_r [3];
  ray_t s1_ray_r, s2_ray_r, s3_ray_r, s4_ray_r;

  // ---------------- stage 2..5: length, shift search, normalize
  logic [LEN_W-1:0] s2_len_r, s3_len_r, s4_len_r;
  logic [PAIRS-1:0] pnz;
  logic [GROUPS-1:0] gnz_nxt;
  logic [1:0] gpos_nxt [GROUPS];
  logic [GROUPS-1:0] s3_gnz_r;
  logic [1:0] s3_gpos_r [GROUPS];
  logic [HP_W-1:0] hp;
  logic [S_W-1:0] s4_s_r;
  logic s4_zero_r;
  logic [NORM_W-1:0] s5_norm_r;
  len_side_t s5_side_r;
  len_side_t s5_side_nxt;

  always_comb begin
    for (int p = 0; p < PAIRS; p++) begin
      pnz[p] = |s2_len_r[2*p +: 2];
    end
    for (int g = 0; g < GROUPS; g++) begin
      gnz_nxt[g] = |pnz[4*g +: 4];
      if (pnz[4*g+3])      gpos_nxt[g] = 2'd3;
      else if (pnz[4*g+2]) gpos_nxt[g] = 2'd2;
      else if (pnz[4*g+1]) gpos_nxt[g] = 2'd1;
      else                 gpos_nxt[g] = 2'd0;
    end
  end

  // highest nonzero bit pair
  always_comb begin
    hp = '0;
    for (int g = 0; g < GROUPS; g++) begin
      if (s3_gnz_r[g]) hp = HP_W'(4 * g) + HP_W'(s3_gpos_r[g]);
    end
  end

  always_comb begin
    logic [MAG_W-1:0] mag;
    s5_side_nxt.zero = s4_zero_r;
    s5_side_nxt.n    = s4_ray_r.n;
    s5_side_nxt.r    = s4_ray_r.r;
    for (int i = 0; i < 3; i++) begin
      s5_side_nxt.neg[i] = s4_ray_r.v[i][VW-1];
      mag = s4_ray_r.v[i][VW-1] ? MAG_W'(-$signed(s4_ray_r.v[i])) : s4_ray_r.v[i];
      s5_side_nxt.mag[i] = MAGS_W'(mag) << s4_s_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s1_sq_r[i] <= vsq[i][SQ_W-1:0];
      end
      s1_ray_r <= in_ray;
      s2_len_r <= LEN_W'(s1_sq_r[0]) + LEN_W'(s1_sq_r[1]) + LEN_W'(s1_sq_r[2]);
      s2_ray_r <= s1_ray_r;
      s3_len_r <= s2_len_r;
      s3_gnz_r <= gnz_nxt;
      s3_gpos_r <= gpos_nxt;
      s3_ray_r <= s2_ray_r;
      s4_len_r <= s3_len_r;
      s4_s_r <= S_W'(TOP_PAIR) - S_W'(hp);
      s4_zero_r <= ~|s3_gnz_r;
      s4_ray_r <= s3_ray_r;
      s5_norm_r <= NORM_W'(s4_len_r) << {s4_s_r, 1'b0};
      s5_side_r <= s5_side_nxt;
    end
  end

  // ---------------- square root of the normalized length
  logic sq1_vld;
  logic [L_W-1:0] sq1_root;
  len_side_t sq1_side;

  srd_isqrt #(
    .IN_W   (NORM_W),
    .SIDE_W ($bits(len_side_t))
  ) u_len_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s5_vld_r),
    .in_x     (s5_norm_r),
    .in_side  (s5_side_r),
    .out_vld  (sq1_vld),
    .out_root (sq1_root),
    .out_side (sq1_side)
  );

  // ---------------- stage 6: dividend with rounding term
  logic s6_vld_r;
  logic [NUM_W-1:0] s6_num_r [3];
  logic [L_W-1:0] s6_den_r;
  div_side_t s6_side_r;

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s6_num_r[i] <= (NUM_W'(sq1_side.mag[i]) << F) + NUM_W'(sq1_root >> 1);
      end
      s6_den_r       <= sq1_root;
      s6_side_r.zero <= sq1_side.zero;
      s6_side_r.neg  <= sq1_side.neg;
      s6_side_r.n    <= sq1_side.n;
      s6_side_r.r    <= sq1_side.r;
    end
  end

  // ---------------- restoring divider, one quotient bit per stage, three lanes
  logic [DIV_STEPS-1:0] dv_vld_r;
  logic [NUM_W-1:0] dv_rem_r   [DIV_STEPS][3];
  logic [NUM_W-1:0] dv_rem_nxt [DIV_STEPS][3];
  logic [NUM_W-1:0] dv_rem_in  [DIV_STEPS][3];
  logic [Q_W-1:0]   dv_q_r     [DIV_STEPS][3];
  logic [Q_W-1:0]   dv_q_nxt   [DIV_STEPS][3];
  logic [Q_W-1:0]   dv_q_in    [DIV_STEPS][3];
  logic [L_W-1:0]   dv_den_r   [DIV_STEPS];
  logic [L_W-1:0]   dv_den_in  [DIV_STEPS];
  div_side_t        dv_side_r  [DIV_STEPS];

  always_comb begin
    dv_den_in[0] = s6_den_r;
    for (int i = 0; i < 3; i++) begin
      dv_rem_in[0][i] = s6_num_r[i];
      dv_q_in[0][i]   = '0;
    end
    for (int k = 1; k < DIV_STEPS; k++) begin
      dv_den_in[k] = dv_den_r[k-1];
      for (int i = 0; i < 3; i++) begin
        dv_rem_in[k][i] = dv_rem_r[k-1][i];
        dv_q_in[k][i]   = dv_q_r[k-1][i];
      end
    end
  end

  always_comb begin
    logic [NUM_W-1:0] trial;
    for (int k = 0; k < DIV_STEPS; k++) begin
      for (int i = 0; i < 3; i++) begin
        trial = NUM_W'(dv_den_in[k]) << (DIV_STEPS - 1 - k);
        if (dv_rem_in[k][i] >= trial) begin
          dv_rem_nxt[k][i] = dv_rem_in[k][i] - trial;
          dv_q_nxt[k][i]   = dv_q_in[k][i] | (Q_W'(1) << (DIV_STEPS - 1 - k));
        end else begin
          dv_rem_nxt[k][i] = dv_rem_in[k][i];
          dv_q_nxt[k][i]   = dv_q_in[k][i];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STEPS; k++) begin
        dv_den_r[k] <= dv_den_in[k];
        for (int i = 0; i < 3; i++) begin
          dv_rem_r[k][i] <= dv_rem_nxt[k][i];
          dv_q_r[k][i]   <= dv_q_nxt[k][i];
        end
      end
      dv_side_r[0] <= s6_side_r;
      for (int k = 1; k < DIV_STEPS; k++) begin
        dv_side_r[k] <= dv_side_r[k-1];
      end
    end
  end

  // ---------------- stages 7..13: dot product, discriminant, tangent part
  div_side_t dv_out;
  assign dv_out = dv_side_r[DIV_STEPS-1];

  logic s7_vld_r, s8_vld_r, s9_vld_r, s10_vld_r, s11_vld_r, s12_vld_r, s13_vld_r;
  logic signed [U_W-1:0] u_nxt [3];
  logic signed [U_W-1:0] s7_u_r [3], s8_u_r [3], s9_u_r [3], s10_u_r [3];
  logic signed [NW-1:0]  s7_n_r [3], s8_n_r [3], s9_n_r [3], s10_n_r [3], s11_n_r [3];
  logic signed [NW-1:0]  s12_n_r [3];
  logic [RAT_W-1:0] s7_r_r, s8_r_r, s9_r_r, s10_r_r, s11_r_r;
  logic s7_zero_r, s8_zero_r, s9_zero_r, s10_zero_r, s11_zero_r, s12_zero_r;
  logic signed [PR_W-1:0]  s8_prod_r [3];
  logic signed [DT_W-1:0]  s9_dt_r;
  logic signed [DSQ_W-1:0] s10_dtsq_r;
  logic [R2_W-1:0]         s10_r2_r, s11_r2_r;
  logic signed [ND_W-1:0]  s10_nd_r [3];
  logic signed [M_W-1:0]   s11_m_r;
  logic signed [W_W-1:0]   s11_w_r [3];
  logic signed [RM_W-1:0]  s12_rm_r;
  logic signed [RWP_W-1:0] s12_rw_r [3];
  logic signed [DISC_W-1:0] disc_nxt;
  logic ok_nxt;
  logic [DSQ_IN_W-1:0] s13_x_r;
  disc_side_t s13_side_r;
  disc_side_t s13_side_nxt;

  always_comb begin
    logic signed [U_W-1:0] qs;
    for (int i = 0; i < 3; i++) begin
      qs       = $signed({1'b0, dv_q_r[DIV_STEPS-1][i]});
      u_nxt[i] = dv_out.neg[i] ? -qs : qs;
    end
  end

  always_comb begin
    disc_nxt = DISC_W'(ONE_F) - DISC_W'(rnd(64'(s12_rm_r), 2 * RF));
    ok_nxt   = !s12_zero_r && (disc_nxt > 0);
    s13_side_nxt.ok = ok_nxt;
    for (int i = 0; i < 3; i++) begin
      s13_side_nxt.p[i] = P_W'(rnd(64'(s12_rw_r[i]), RF));
      s13_side_nxt.n[i] = s12_n_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // 7: signed unit vector
      for (int i = 0; i < 3; i++) begin
        s7_u_r[i] <= u_nxt[i];
        s7_n_r[i] <= $signed(dv_out.n[i]);
      end
      s7_r_r    <= dv_out.r;
      s7_zero_r <= dv_out.zero;
      // 8: u*n
      for (int i = 0; i < 3; i++) begin
        s8_prod_r[i] <= PR_W'(s7_u_r[i]) * PR_W'(s7_n_r[i]);
        s8_u_r[i]    <= s7_u_r[i];
        s8_n_r[i]    <= s7_n_r[i];
      end
      s8_r_r    <= s7_r_r;
      s8_zero_r <= s7_zero_r;
      // 9: dt
      s9_dt_r <= DT_W'(rnd(64'(ACC_W'(s8_prod_r[0]) + ACC_W'(s8_prod_r[1])
                                + ACC_W'(s8_prod_r[2])), F));
      s9_u_r    <= s8_u_r;
      s9_n_r    <= s8_n_r;
      s9_r_r    <= s8_r_r;
      s9_zero_r <= s8_zero_r;
      // 10: dt^2, r^2, n*dt
      s10_dtsq_r <= DSQ_W'(s9_dt_r) * DSQ_W'(s9_dt_r);
      s10_r2_r   <= R2_W'(s9_r_r) * R2_W'(s9_r_r);
      for (int i = 0; i < 3; i++) begin
        s10_nd_r[i] <= ND_W'(s9_n_r[i]) * ND_W'(s9_dt_r);
      end
      s10_u_r    <= s9_u_r;
      s10_n_r    <= s9_n_r;
      s10_r_r    <= s9_r_r;
      s10_zero_r <= s9_zero_r;
      // 11: m = 1 - dt^2, w = u - n dt
      s11_m_r <= M_W'(ONE_F) - M_W'(rnd(64'(s10_dtsq_r), F));
      for (int i = 0; i < 3; i++) begin
        s11_w_r[i] <= W_W'(s10_u_r[i]) - W_W'(rnd(64'(s10_nd_r[i]), F));
      end
      s11_r2_r   <= s10_r2_r;
      s11_n_r    <= s10_n_r;
      s11_r_r    <= s10_r_r;
      s11_zero_r <= s10_zero_r;
      // 12: r^2 m, r w
      s12_rm_r <= RM_W'($signed({1'b0, s11_r2_r})) * RM_W'(s11_m_r);
      for (int i = 0; i < 3; i++) begin
        s12_rw_r[i] <= RWP_W'($signed({1'b0, s11_r_r})) * RWP_W'(s11_w_r[i]);
      end
      s12_n_r    <= s11_n_r;
      s12_zero_r <= s11_zero_r;
      // 13: discriminant, feed root only when it is positive
      s13_x_r    <= ok_nxt ? (DSQ_IN_W'(disc_nxt[DISC_MAG_W-1:0]) << F) : '0;
      s13_side_r <= s13_side_nxt;
    end
  end

  // ---------------- square root of the discriminant
  logic sq2_vld;
  logic [SQ2_W-1:0] sq2_root;
  disc_side_t sq2_side;

  srd_isqrt #(
    .IN_W   (DSQ_IN_W),
    .SIDE_W ($bits(disc_side_t))
  ) u_disc_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s13_vld_r),
    .in_x     (s13_x_r),
    .in_side  (s13_side_r),
    .out_vld  (sq2_vld),
    .out_root (sq2_root),
    .out_side (sq2_side)
  );

  // ---------------- stages 14, 15: normal part, saturate, output register
  logic s14_vld_r;
  logic signed [QN_W-1:0] s14_qn_r [3];
  disc_side_t s14_side_r;
  logic [OUT_DATA_W-1:0] out_nxt;

  always_comb begin
    logic signed [O_PRE_W-1:0] o;
    for (int i = 0; i < 3; i++) begin
      o = O_PRE_W'($signed(s14_side_r.p[i])) - O_PRE_W'(rnd(64'(s14_qn_r[i]), F));
      out_nxt[i*OW +: OW] = s14_side_r.ok ? sat_out(o) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        s14_qn_r[i] <= QN_W'($signed(sq2_side.n[i])) * QN_W'($signed({1'b0, sq2_root}));
      end
      s14_side_r <= sq2_side;
      out_tdata  <= out_nxt;
      out_tuser  <= s14_side_r.ok;
    end
  end

  // ---------------- valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r   <= 1'b0;
      s2_vld_r   <= 1'b0;
      s3_vld_r   <= 1'b0;
      s4_vld_r   <= 1'b0;
      s5_vld_r   <= 1'b0;
      s6_vld_r   <= 1'b0;
      dv_vld_r   <= '0;
      s7_vld_r   <= 1'b0;
      s8_vld_r   <= 1'b0;
      s9_vld_r   <= 1'b0;
      s10_vld_r  <= 1'b0;
      s11_vld_r  <= 1'b0;
      s12_vld_r  <= 1'b0;
      s13_vld_r  <= 1'b0;
      s14_vld_r  <= 1'b0;
      out_tvalid <= 1'b0;
    end else if (en) begin
      s1_vld_r   <= in_tvalid;
      s2_vld_r   <= s1_vld_r;
      s3_vld_r   <= s2_vld_r;
      s4_vld_r   <= s3_vld_r;
      s5_vld_r   <= s4_vld_r;
      s6_vld_r   <= sq1_vld;
      dv_vld_r   <= (dv_vld_r << 1) | DIV_STEPS'(s6_vld_r);
      s7_vld_r   <= dv_vld_r[DIV_STEPS-1];
      s8_vld_r   <= s7_vld_r;
      s9_vld_r   <= s8_vld_r;
      s10_vld_r  <= s9_vld_r;
      s11_vld_r  <= s10_vld_r;
      s12_vld_r  <= s11_vld_r;
      s13_vld_r  <= s12_vld_r;
      s14_vld_r  <= sq2_vld;
      out_tvalid <= s14_vld_r;
    end
  end

  // ---------------- checks
  logic unit_ok;
  assign unit_ok = (dv_q_r[DIV_STEPS-1][0] <= Q_W'(Q_MAX))
                && (dv_q_r[DIV_STEPS-1][1] <= Q_W'(Q_MAX))
                && (dv_q_r[DIV_STEPS-1][2] <= Q_W'(Q_MAX));

  `SRD_ASSERT_IMP(a_len_norm, sq1_vld && !sq1_side.zero, sq1_root[L_W-1], "length root low")
  `SRD_ASSERT_IMP(a_unit_bound, dv_vld_r[DIV_STEPS-1] && !dv_out.zero, unit_ok, "unit above one")
  `SRD_ASSERT_IMP(a_disc_root, sq2_vld && sq2_side.ok, sq2_root != '0, "disc root zero")
  `SRD_ASSERT_IMP(a_tir_zero, out_tvalid && !out_tuser[0], out_tdata == '0, "tir word not zero")

endmodule
